### sv/fwt_pkg.sv
// fwt_pkg: shared types and constants for the forth word tokenizer
// holds scan modes, result kinds, character codes and the result word layout
// no dependencies

package fwt_pkg;

  // longest word before it is cut
  localparam int MAX_TOKEN = 202;
  localparam logic [7:0] CNT_MAX = 8'(MAX_TOKEN);

  // result queue depth and pointer width
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // special characters
  localparam logic [7:0] CH_NUL         = 8'h00;
  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
  localparam logic [7:0] CH_BACKSLASH   = 8'h5C;

  typedef enum logic [2:0] {
    MODE_SKIP  = 3'd0,
    MODE_HELD  = 3'd1,
    MODE_WORD  = 3'd2,
    MODE_PAREN = 3'd3,
    MODE_LINE  = 3'd4,
    MODE_CUT   = 3'd5
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] word_char;
    logic [7:0] word_length;
  } result_t;

  // scanner state as seen from outside the step unit
  typedef struct packed {
    scan_mode_t mode;
    logic [7:0] held_char;
    logic [7:0] char_count;
  } scan_state_t;

  // what one step pushes into the result queue
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_status_t;

endpackage

### sv/fwt_step.sv
// fwt_step: scanner state registers and the per-character step logic
// produces zero to two results for one input word
// depends on fwt_pkg

module fwt_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 action,
  input  logic [7:0]           character,
  input  logic [7:0]           delimiter,
  output fwt_pkg::push_t       push,
  output fwt_pkg::scan_state_t state
);

  fwt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] count_r, count_nxt;

  logic            is_end;
  logic            is_delim;
  logic            is_special;
  logic [7:0]      count_inc;
  fwt_pkg::result_t skip_res;
  logic            skip_has;

  assign is_end     = action || (character == fwt_pkg::CH_NUL);
  assign is_delim   = (character == delimiter);
  assign is_special = (character inside {fwt_pkg::CH_PAREN_OPEN, fwt_pkg::CH_BACKSLASH});
  assign count_inc  = 8'(count_r + 8'd1);

  // result of starting a word search
  assign skip_has = is_end || (!is_delim && !is_special);
  always_comb begin
    skip_res = '{kind: fwt_pkg::KIND_CHAR, word_char: character, word_length: 8'd0};
    if (is_end) begin
      skip_res = '{kind: fwt_pkg::KIND_NONE, word_char: 8'd0, word_length: 8'd0};
    end
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    unique case (mode_r)
      fwt_pkg::MODE_HELD: begin
        if (is_end) begin
          mode_nxt = fwt_pkg::MODE_SKIP;
        end else if (is_delim) begin
          mode_nxt = (held_r == fwt_pkg::CH_PAREN_OPEN) ? fwt_pkg::MODE_PAREN
                                                        : fwt_pkg::MODE_LINE;
        end else begin
          count_nxt = 8'd2;
          mode_nxt  = (8'd2 >= fwt_pkg::CNT_MAX) ? fwt_pkg::MODE_CUT : fwt_pkg::MODE_WORD;
        end
      end
      fwt_pkg::MODE_WORD: begin
        if (is_end || is_delim) begin
          mode_nxt = fwt_pkg::MODE_SKIP;
        end else begin
          count_nxt = count_inc;
          mode_nxt  = (count_inc >= fwt_pkg::CNT_MAX) ? fwt_pkg::MODE_SKIP
                                                      : fwt_pkg::MODE_WORD;
        end
      end
      fwt_pkg::MODE_PAREN: begin
        if (is_end || character == fwt_pkg::CH_PAREN_CLOSE) begin
          mode_nxt = fwt_pkg::MODE_SKIP;
        end
      end
      fwt_pkg::MODE_LINE: begin
        if (is_end || character == fwt_pkg::CH_NEWLINE) begin
          mode_nxt = fwt_pkg::MODE_SKIP;
        end
      end
      default: begin
        // skip and owed-cut both start a new word search
        if (is_end || is_delim) begin
          mode_nxt = fwt_pkg::MODE_SKIP;
        end else if (is_special) begin
          held_nxt = character;
          mode_nxt = fwt_pkg::MODE_HELD;
        end else begin
          count_nxt = 8'd1;
          mode_nxt  = fwt_pkg::MODE_WORD;
        end
      end
    endcase
  end

  // results
  always_comb begin
    push.num  = 2'd0;
    push.res0 = '{kind: fwt_pkg::KIND_NONE, word_char: 8'd0, word_length: 8'd0};
    push.res1 = '{kind: fwt_pkg::KIND_NONE, word_char: 8'd0, word_length: 8'd0};
    unique case (mode_r)
      fwt_pkg::MODE_HELD: begin
        if (is_end) begin
          push.num = 2'd1;
        end else if (!is_delim) begin
          push.num  = 2'd2;
          push.res0 = '{kind: fwt_pkg::KIND_CHAR, word_char: held_r, word_length: 8'd0};
          push.res1 = '{kind: fwt_pkg::KIND_CHAR, word_char: character, word_length: 8'd0};
        end
      end
      fwt_pkg::MODE_WORD: begin
        if (is_end) begin
          push.num  = 2'd2;
          push.res0 = '{kind: fwt_pkg::KIND_END, word_char: 8'd0, word_length: count_r};
        end else if (is_delim) begin
          push.num  = 2'd1;
          push.res0 = '{kind: fwt_pkg::KIND_END, word_char: 8'd0, word_length: count_r};
        end else begin
          push.res0 = '{kind: fwt_pkg::KIND_CHAR, word_char: character, word_length: 8'd0};
          push.res1 = '{kind: fwt_pkg::KIND_END, word_char: 8'd0, word_length: count_inc};
          push.num  = (count_inc >= fwt_pkg::CNT_MAX) ? 2'd2 : 2'd1;
        end
      end
      fwt_pkg::MODE_PAREN: begin
        if (is_end) begin
          push.num = 2'd1;
        end
      end
      fwt_pkg::MODE_LINE: begin
        if (is_end || character == fwt_pkg::CH_NEWLINE) begin
          push.num = 2'd1;
        end
      end
      fwt_pkg::MODE_CUT: begin
        // owed word end goes ahead of this character's own result
        push.res0 = '{kind: fwt_pkg::KIND_END, word_char: 8'd0, word_length: count_r};
        push.res1 = skip_res;
        push.num  = skip_has ? 2'd2 : 2'd1;
      end
      default: begin
        push.res0 = skip_res;
        push.num  = skip_has ? 2'd1 : 2'd0;
      end
    endcase
    if (!step_en) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fwt_pkg::MODE_SKIP;
      held_r  <= 8'd0;
      count_r <= 8'd0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
    end
  end

  assign state = '{mode: mode_r, held_char: held_r, char_count: count_r};

endmodule

### sv/fwt_fifo.sv
// fwt_fifo: small result queue that takes up to two results per cycle
// and hands out one per cycle on the output stream while pop is high
// depends on fwt_pkg

module fwt_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fwt_pkg::push_t        push,
  input  logic                  pop,
  output fwt_pkg::result_t      head,
  output logic                  head_vld,
  output fwt_pkg::fifo_status_t status
);

  fwt_pkg::result_t entry_r [fwt_pkg::FIFO_DEPTH];
  logic [fwt_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fwt_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fwt_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [fwt_pkg::PTR_W-1:0] wr_ptr_p1;
  logic                      do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign wr_ptr_p1 = fwt_pkg::PTR_W'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = fwt_pkg::PTR_W'(wr_ptr_r + fwt_pkg::PTR_W'(push.num));
    rd_ptr_nxt = fwt_pkg::PTR_W'(rd_ptr_r + fwt_pkg::PTR_W'(do_pop));
    count_nxt  = fwt_pkg::CNT_W'(count_r + fwt_pkg::CNT_W'(push.num)
                                 - fwt_pkg::CNT_W'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.res1;
    end
  end

  assign head     = entry_r[rd_ptr_r];
  assign head_vld = (count_r != '0);

  // room for a full two-result step without counting this cycle's pop
  assign status.count = count_r;
  assign status.room  = (count_r <= fwt_pkg::CNT_W'(fwt_pkg::FIFO_DEPTH - 2));

endmodule

### sv/forth_word_tokenizer.sv
// forth_word_tokenizer: top level of the stream word tokenizer
// input register, step unit fwt_step and result queue fwt_fifo
// depends on fwt_pkg, fwt_step, fwt_fifo
//
//  channel | direction | tdata                          | tuser
//  --------+-----------+--------------------------------+-------------
//  in_     | slave     | [7:0] character [15:8] delim   | [0] action
//  out_    | master    | [7:0] word_char [15:8] length  | [1:0] kind
//
// one input word per clock while the queue has room; each word is scanned
// from the input register once the queue can take its results, and its
// zero to two results land in a four-entry result queue that drains one
// result per clock while out_tready is high; two-result words (word end
// plus no-word, held pair, cut words) need a second output transfer, so the
// sustained rate is one word per clock only while results average one per word
// reset (rst_n low, synchronous) returns the scanner to skipping delimiters
// and empties the queue
// a stalled out_tready fills the queue; the step unit waits for room for two
// results, and in_tready then drops once the input register is occupied

module forth_word_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] character, [15:8] delimiter
  input  logic [0:0]  in_tuser,   // [0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] word_char, [15:8] word_length
  output logic [1:0]  out_tuser   // [1:0] kind
);

  // input register
  logic       in_vld_r;
  logic       action_r;
  logic [7:0] char_r;
  logic [7:0] delim_r;

  logic                  step_en;
  fwt_pkg::push_t        push;
  fwt_pkg::scan_state_t  scan_state;
  fwt_pkg::result_t      head;
  logic                  head_vld;
  fwt_pkg::fifo_status_t fifo_status;

  // the held word is scanned once the queue can take both of its results
  assign step_en   = in_vld_r && fifo_status.room;
  assign in_tready = !in_vld_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= in_tuser[0];
      char_r   <= in_tdata[7:0];
      delim_r  <= in_tdata[15:8];
    end
  end

  fwt_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .action    (action_r),
    .character (char_r),
    .delimiter (delim_r),
    .push      (push),
    .state     (scan_state)
  );

  fwt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_tready),
    .head     (head),
    .head_vld (head_vld),
    .status   (fifo_status)
  );

  assign out_tvalid = head_vld;
  assign out_tdata  = {head.word_length, head.word_char};
  assign out_tuser  = head.kind;

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_status.count <= fwt_pkg::CNT_W'(fwt_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a step that produced results shows one on the output next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |=> out_tvalid)
    else $error("pushed result not visible");

  // only an open paren or a backslash is ever held back
  a_held_char: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_state.mode == fwt_pkg::MODE_HELD) |->
      (scan_state.held_char == fwt_pkg::CH_PAREN_OPEN ||
       scan_state.held_char == fwt_pkg::CH_BACKSLASH))
    else $error("held character is not a comment opener");

  // an open word always has at least one and fewer than the cut length chars
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_state.mode == fwt_pkg::MODE_WORD) |->
      (scan_state.char_count != 8'd0 && scan_state.char_count < fwt_pkg::CNT_MAX))
    else $error("open word length out of range");

endmodule

### sim/tb.sv
// tb: self-checking regression for the forth word tokenizer stream block
// drives the in_ stream, predicts the result stream with a scoreboard class
// depends on fwt_pkg and forth_word_tokenizer
`timescale 1ns / 100ps

module tb;

  // run shape
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES  = 120;  // long receiver hold-off, fills the queue
  localparam int DRAIN_CYCLES = 16;   // settle time after the last result
  localparam logic [7:0] SPACE = 8'h20;

  // scoreboard: tracks the scanner and the results it should produce
  class token_board;
    fwt_pkg::scan_mode_t mode;
    logic [7:0]          held;
    logic [7:0]          count;
    fwt_pkg::result_t    pending_tokens[$];
    int                  errors;

    function new();
      mode   = fwt_pkg::MODE_SKIP;
      held   = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void push(fwt_pkg::kind_t k, logic [7:0] c, logic [7:0] len);
      fwt_pkg::result_t r;
      r.kind        = k;
      r.word_char   = c;
      r.word_length = len;
      pending_tokens.push_back(r);
    endfunction

    // looking for the first character of a word
    function void start_search(bit at_end, logic [7:0] c, logic [7:0] d);
      if (at_end) begin
        push(fwt_pkg::KIND_NONE, 8'h00, 8'h00);
        mode = fwt_pkg::MODE_SKIP;
      end else if (c == d) begin
        mode = fwt_pkg::MODE_SKIP;
      end else if (c == fwt_pkg::CH_PAREN_OPEN || c == fwt_pkg::CH_BACKSLASH) begin
        held = c;
        mode = fwt_pkg::MODE_HELD;
      end else begin
        push(fwt_pkg::KIND_CHAR, c, 8'h00);
        count = 8'd1;
        mode  = fwt_pkg::MODE_WORD;
      end
    endfunction

    // one accepted input word
    function void note_word(logic act, logic [7:0] c, logic [7:0] d);
      bit at_end;
      // a zero byte ends the line just like the action bit
      at_end = act || (c == fwt_pkg::CH_NUL);
      case (mode)
        fwt_pkg::MODE_HELD: begin
          if (at_end) begin
            // lone comment opener at end of line: no word end for it
            push(fwt_pkg::KIND_NONE, 8'h00, 8'h00);
            mode = fwt_pkg::MODE_SKIP;
          end else if (c == d) begin
            mode = (held == fwt_pkg::CH_PAREN_OPEN) ? fwt_pkg::MODE_PAREN
                                                    : fwt_pkg::MODE_LINE;
          end else begin
            push(fwt_pkg::KIND_CHAR, held, 8'h00);
            push(fwt_pkg::KIND_CHAR, c, 8'h00);
            count = 8'd2;
            mode  = (count >= fwt_pkg::CNT_MAX) ? fwt_pkg::MODE_CUT : fwt_pkg::MODE_WORD;
          end
        end
        fwt_pkg::MODE_WORD: begin
          if (at_end) begin
            push(fwt_pkg::KIND_END, 8'h00, count);
            push(fwt_pkg::KIND_NONE, 8'h00, 8'h00);
            mode = fwt_pkg::MODE_SKIP;
          end else if (c == d) begin
            push(fwt_pkg::KIND_END, 8'h00, count);
            mode = fwt_pkg::MODE_SKIP;
          end else begin
            push(fwt_pkg::KIND_CHAR, c, 8'h00);
            count = count + 8'd1;
            if (count >= fwt_pkg::CNT_MAX) begin
              push(fwt_pkg::KIND_END, 8'h00, count);
              mode = fwt_pkg::MODE_SKIP;
            end
          end
        end
        fwt_pkg::MODE_PAREN: begin
          // delimiter is not looked at inside a paren comment
          if (at_end) begin
            push(fwt_pkg::KIND_NONE, 8'h00, 8'h00);
            mode = fwt_pkg::MODE_SKIP;
          end else if (c == fwt_pkg::CH_PAREN_CLOSE) begin
            mode = fwt_pkg::MODE_SKIP;
          end
        end
        fwt_pkg::MODE_LINE: begin
          if (at_end || c == fwt_pkg::CH_NEWLINE) begin
            push(fwt_pkg::KIND_NONE, 8'h00, 8'h00);
            mode = fwt_pkg::MODE_SKIP;
          end
        end
        fwt_pkg::MODE_CUT: begin
          // owed word end goes ahead of this word's own results
          push(fwt_pkg::KIND_END, 8'h00, count);
          start_search(at_end, c, d);
        end
        default: start_search(at_end, c, d);
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_token(logic [1:0] k, logic [7:0] c, logic [7:0] len);
      fwt_pkg::result_t want;
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %h len %0d", k, c, len));
      end else begin
        want = pending_tokens.pop_front();
        if (k != want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", k, want.kind));
        if (c != want.word_char)
          report_mismatch($sformatf("word_char %h, want %h", c, want.word_char));
        if (len != want.word_length)
          report_mismatch($sformatf("word_length %0d, want %0d", len, want.word_length));
      end
    endtask

    function int outstanding();
      return pending_tokens.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  token_board board = new();

  // pacing controls shared by the sender and the receiver
  bit calm         = 1'b0;  // no idling on either side while set
  bit holdoff_req  = 1'b0;  // receiver holds off for HOLD_CYCLES
  int words_sent   = 0;

  always #1 clk = ~clk;

  forth_word_tokenizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] character, [15:8] delimiter
    .in_tuser   (in_tuser),    // [0] action
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] word_char, [15:8] word_length
    .out_tuser  (out_tuser)    // [1:0] kind
  );

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 80) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // delimiter for one sequence: normally space, sometimes any nonzero byte
  function automatic logic [7:0] pick_delim();
    if ($urandom_range(0, 99) < 88) return SPACE;
    return 8'($urandom_range(1, 255));
  endfunction

  // printable word character that is not the delimiter
  function automatic logic [7:0] word_letter(logic [7:0] d);
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (c == d) c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  // offer one word until taken, then idle for a random gap
  task automatic send_word(input logic act, input logic [7:0] ch, input logic [7:0] d);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {d, ch};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_word(act, ch, d);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause: nothing offered until every expected result is out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // ordinary word followed by one or two delimiters
  task automatic send_text_word(input int len, input logic [7:0] d);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = word_letter(d);
      // keep the first letter away from the comment openers
      if (i == 0 && (c == fwt_pkg::CH_PAREN_OPEN || c == fwt_pkg::CH_BACKSLASH)) c = "w";
      send_word(1'b0, c, d);
    end
    repeat ($urandom_range(1, 2)) send_word(1'b0, d, d);
  endtask

  // ( ... ) with random body bytes
  task automatic send_paren_comment(input logic [7:0] d);
    logic [7:0] c;
    send_word(1'b0, fwt_pkg::CH_PAREN_OPEN, d);
    send_word(1'b0, d, d);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(1, 255));
      if (c == fwt_pkg::CH_PAREN_CLOSE) c = "p";
      send_word(1'b0, c, d);
    end
    send_word(1'b0, fwt_pkg::CH_PAREN_CLOSE, d);
    send_word(1'b0, d, d);
  endtask

  // backslash comment up to newline
  task automatic send_line_comment(input logic [7:0] d);
    logic [7:0] c;
    send_word(1'b0, fwt_pkg::CH_BACKSLASH, d);
    send_word(1'b0, d, d);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(1, 255));
      if (c == fwt_pkg::CH_NEWLINE) c = "n";
      send_word(1'b0, c, d);
    end
    send_word(1'b0, fwt_pkg::CH_NEWLINE, d);
  endtask

  // end of line either by the action bit or by a zero byte
  task automatic send_line_end(input logic [7:0] d);
    if ($urandom_range(0, 1)) send_word(1'b1, 8'($urandom_range(0, 255)), d);
    else send_word(1'b0, fwt_pkg::CH_NUL, d);
  endtask

  // receiver: random ready runs, long hold-off on request
  initial begin : receiver
    int run;
    logic rdy;
    forever begin
      if (holdoff_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end else begin
        rdy = calm ? 1'b1 : ($urandom_range(0, 3) != 0);
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
        out_tready <= rdy;
        repeat (run) @(posedge clk);
      end
    end
  end

  // result monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_token(out_tuser, out_tdata[7:0], out_tdata[15:8]);
    end
  end

  // run limit well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("forth_word_tokenizer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int r;
    int phase_mark;
    bit pressure_done;
    logic [7:0] d;

    phase_mark    = 0;
    pressure_done = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and the corner cases of the scanner
    send_word(1'b0, "a", SPACE);             // one-letter word
    send_word(1'b0, SPACE, SPACE);
    send_word(1'b0, 8'hFF, SPACE);           // top byte as word letter
    send_word(1'b0, 8'h01, SPACE);           // lowest nonzero byte
    send_word(1'b0, SPACE, SPACE);
    send_word(1'b0, fwt_pkg::CH_PAREN_OPEN, SPACE);   // paren comment
    send_word(1'b0, SPACE, SPACE);
    send_word(1'b0, "x", SPACE);
    send_word(1'b0, fwt_pkg::CH_PAREN_CLOSE, SPACE);
    send_word(1'b0, "b", SPACE);             // word closed by end of line
    send_word(1'b1, 8'hFF, 8'hFF);
    send_word(1'b0, fwt_pkg::CH_BACKSLASH, SPACE);    // line comment
    send_word(1'b0, SPACE, SPACE);
    send_word(1'b0, "z", SPACE);
    send_word(1'b0, fwt_pkg::CH_NEWLINE, SPACE);
    // opener used as delimiter
    send_word(1'b0, fwt_pkg::CH_PAREN_OPEN, fwt_pkg::CH_PAREN_OPEN);
    send_word(1'b0, fwt_pkg::CH_BACKSLASH, fwt_pkg::CH_BACKSLASH);
    send_word(1'b0, "c", 8'h00);             // zero byte ends an open word
    send_word(1'b0, fwt_pkg::CH_NUL, 8'h00);
    send_word(1'b0, fwt_pkg::CH_PAREN_OPEN, SPACE);   // paren comment cut by end of line
    send_word(1'b0, SPACE, SPACE);
    send_word(1'b1, 8'h00, SPACE);
    send_word(1'b0, fwt_pkg::CH_BACKSLASH, SPACE);    // lone opener then end of line
    send_word(1'b1, 8'h00, SPACE);
    send_word(1'b0, fwt_pkg::CH_PAREN_OPEN, 8'hFF);   // held opener starts a real word
    send_word(1'b0, "q", 8'hFF);
    send_word(1'b0, 8'hFF, 8'hFF);

    // one word past the cut length, so the cut and the next word both show
    send_text_word(fwt_pkg::MAX_TOKEN + 1, SPACE);

    phase_mark = words_sent;
    while (words_sent < RANDOM_WORDS + 28) begin
      // phase boundary: sometimes pause the sender, pick new pacing
      if (words_sent - phase_mark >= 250) begin
        phase_mark = words_sent;
        if ($urandom_range(0, 1)) wait_results_drained();
        calm = ($urandom_range(0, 3) == 0);
      end

      // back pressure: receiver stops while the sender streams
      if (!pressure_done && words_sent > 400) begin
        holdoff_req = 1'b1;
        calm = 1'b1;
        repeat (12) send_text_word($urandom_range(3, 8), SPACE);
        calm = 1'b0;
        pressure_done = 1'b1;
        wait_results_drained();
      end

      d = pick_delim();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 149) == 0) send_text_word($urandom_range(195, 210), d);
        else send_text_word($urandom_range(1, 8), d);
      end else if (r < 55) begin
        send_paren_comment(d);
      end else if (r < 63) begin
        send_line_comment(d);
      end else if (r < 70) begin
        send_line_end(d);
      end else if (r < 78) begin
        // lone opener right before end of line
        send_word(1'b0,
                  $urandom_range(0, 1) ? fwt_pkg::CH_PAREN_OPEN : fwt_pkg::CH_BACKSLASH,
                  d);
        if ($urandom_range(0, 1)) send_word(1'b0, d, d);
        send_line_end(d);
      end else begin
        // noise: any byte, any delimiter, rare end of line
        repeat ($urandom_range(1, 4))
          send_word($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : SPACE);
      end
    end

    // wind down: let every expected result through, then settle
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.outstanding() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.outstanding()));
    if (board.errors == 0) begin
      $display("forth_word_tokenizer regression: pass");
    end else begin
      $display("forth_word_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
